### hw/rtl/qbv_pkg.sv
// qbv_pkg: shared constants and types for the quaternion to basis vectors unit
// no dependencies; imported by qbv_front, qbv_div_lane and the top level
`default_nettype none

package qbv_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRONT_STAGES   = 4;
    localparam int NUM_LANES      = 9;

    // constant term added to a matrix entry, in units of one
    typedef enum logic [1:0] {
        BASE_ZERO = 2'd0,
        BASE_POS1 = 2'd1,
        BASE_NEG1 = 2'd2
    } base_t;

    // lane order: left a/b/c, up a/b/c, fwd a/b/c
    function automatic base_t lane_base(input int k);
        base_t b;
        case (k)
            0:       b = BASE_NEG1;
            4:       b = BASE_POS1;
            8:       b = BASE_POS1;
            default: b = BASE_ZERO;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/qbv_front.sv
// qbv_front: halving, products, numerator sums and sign/magnitude split
// four register stages; depends on qbv_pkg
`default_nettype none

module qbv_front #(
    parameter int W = 16
) (
    input  wire logic                                   aclk,
    input  wire logic [qbv_pkg::FRONT_STAGES-1:0]       ld,
    input  wire logic signed [W-1:0]                    x,
    input  wire logic signed [W-1:0]                    y,
    input  wire logic signed [W-1:0]                    z,
    input  wire logic signed [W-1:0]                    w,
    output logic [2*W:0]                                s_out,
    output logic                                        zero_out,
    output logic                                        neg_out [qbv_pkg::NUM_LANES],
    output logic [2*W:0]                                mag_out [qbv_pkg::NUM_LANES]
);
    import qbv_pkg::*;

    localparam int SW = 2*W + 1;

    logic                   even;
    logic signed [W-1:0]    cx_reg, cy_reg, cz_reg, cw_reg;
    logic signed [2*W-1:0]  pxx_reg, pyy_reg, pzz_reg, pww_reg;
    logic signed [2*W-1:0]  pxy_reg, pzw_reg, pxz_reg, pyw_reg, pyz_reg, pxw_reg;
    logic signed [SW-1:0]   exx, eyy, ezz, eww, exy, ezw, exz, eyw, eyz, exw;
    logic signed [SW-1:0]   p_next [NUM_LANES];
    logic signed [SW-1:0]   p_reg  [NUM_LANES];
    logic [SW-1:0]          s3_next, s3_reg, s4_reg;
    logic                   zero_reg;
    logic                   neg_reg [NUM_LANES];
    logic [SW-1:0]          mag_reg [NUM_LANES];

    // all even: halve, exact since the ratios do not change
    assign even = ~(x[0] | y[0] | z[0] | w[0]);

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            cx_reg <= even ? (x >>> 1) : x;
            cy_reg <= even ? (y >>> 1) : y;
            cz_reg <= even ? (z >>> 1) : z;
            cw_reg <= even ? (w >>> 1) : w;
        end
        if (ld[1]) begin
            pxx_reg <= cx_reg * cx_reg;
            pyy_reg <= cy_reg * cy_reg;
            pzz_reg <= cz_reg * cz_reg;
            pww_reg <= cw_reg * cw_reg;
            pxy_reg <= cx_reg * cy_reg;
            pzw_reg <= cz_reg * cw_reg;
            pxz_reg <= cx_reg * cz_reg;
            pyw_reg <= cy_reg * cw_reg;
            pyz_reg <= cy_reg * cz_reg;
            pxw_reg <= cx_reg * cw_reg;
        end
    end

    always_comb begin
        exx = SW'(pxx_reg);
        eyy = SW'(pyy_reg);
        ezz = SW'(pzz_reg);
        eww = SW'(pww_reg);
        exy = SW'(pxy_reg);
        ezw = SW'(pzw_reg);
        exz = SW'(pxz_reg);
        eyw = SW'(pyw_reg);
        eyz = SW'(pyz_reg);
        exw = SW'(pxw_reg);
        s3_next   = SW'(exx + eyy + ezz + eww);
        p_next[0] = eyy + ezz;
        p_next[1] = exy + ezw;
        p_next[2] = exz - eyw;
        p_next[3] = ezw - exy;
        p_next[4] = -(exx + ezz);
        p_next[5] = eyz + exw;
        p_next[6] = -(exz + eyw);
        p_next[7] = eyz - exw;
        p_next[8] = -(exx + eyy);
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            s3_reg <= s3_next;
            for (int k = 0; k < NUM_LANES; k++) begin
                p_reg[k] <= p_next[k];
            end
        end
        if (ld[3]) begin
            s4_reg   <= s3_reg;
            zero_reg <= (s3_reg == '0);
            for (int k = 0; k < NUM_LANES; k++) begin
                neg_reg[k] <= p_reg[k][SW-1];
                mag_reg[k] <= p_reg[k][SW-1] ? SW'(-p_reg[k]) : SW'(p_reg[k]);
            end
        end
    end

    assign s_out    = s4_reg;
    assign zero_out = zero_reg;
    assign neg_out  = neg_reg;
    assign mag_out  = mag_reg;

endmodule

`default_nettype wire

### hw/rtl/qbv_div_lane.sv
// qbv_div_lane: one matrix entry, restoring divide one bit per stage,
// then rounding, sign, constant term and saturation; depends on qbv_pkg
`default_nettype none

module qbv_div_lane #(
    parameter int W = 16
) (
    input  wire logic                   aclk,
    input  wire logic [W+2:0]           ld,
    input  wire qbv_pkg::base_t         base,
    input  wire logic                   neg,
    input  wire logic [2*W:0]           mag,
    input  wire logic [2*W:0]           s,
    output logic signed [W-1:0]         value
);
    import qbv_pkg::*;

    localparam int SW = 2*W + 1;
    localparam int QW = W + 2;
    localparam int DS = W + 2;
    localparam logic signed [W+1:0] MAXV = (W+2)'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [W+1:0] MINV = (W+2)'(-(64'sd1 <<< (W-1)));
    localparam logic signed [W+1:0] ONEV = (W+2)'(64'sd1 <<< (W-1));

    logic [SW-1:0]  rem_reg  [DS];
    logic [QW-1:0]  q_reg    [DS];
    logic [SW-1:0]  s_reg    [DS];
    logic           neg_reg  [DS];
    base_t          base_reg [DS];
    logic signed [W-1:0] value_reg;

    // integer bit first, then W+1 fraction bits, one extra so the quotient can be rounded
    for (genvar j = 0; j < DS; j++) begin : g_bit
        logic [SW:0]    rem2;
        logic           qbit;
        logic [SW-1:0]  rem_n;
        logic [QW-1:0]  q_n;
        if (j == 0) begin : g_first
            always_comb begin
                rem2  = {1'b0, mag};
                qbit  = (rem2 >= {1'b0, s});
                rem_n = qbit ? SW'(rem2 - {1'b0, s}) : SW'(rem2);
                q_n   = {{(QW-1){1'b0}}, qbit};
            end
            always_ff @(posedge aclk) begin
                if (ld[j]) begin
                    rem_reg[j]  <= rem_n;
                    q_reg[j]    <= q_n;
                    s_reg[j]    <= s;
                    neg_reg[j]  <= neg;
                    base_reg[j] <= base;
                end
            end
        end else begin : g_next
            always_comb begin
                rem2  = {rem_reg[j-1], 1'b0};
                qbit  = (rem2 >= {1'b0, s_reg[j-1]});
                rem_n = qbit ? SW'(rem2 - {1'b0, s_reg[j-1]}) : SW'(rem2);
                q_n   = {q_reg[j-1][QW-2:0], qbit};
            end
            always_ff @(posedge aclk) begin
                if (ld[j]) begin
                    rem_reg[j]  <= rem_n;
                    q_reg[j]    <= q_n;
                    s_reg[j]    <= s_reg[j-1];
                    neg_reg[j]  <= neg_reg[j-1];
                    base_reg[j] <= base_reg[j-1];
                end
            end
        end
    end

    logic [QW-1:0]          qp1;
    logic [W:0]             r;
    logic signed [W+1:0]    rs, bterm, val;
    logic signed [W-1:0]    value_next;

    always_comb begin
        qp1 = q_reg[DS-1] + QW'(1);
        r   = qp1[QW-1:1];
        rs  = neg_reg[DS-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        case (base_reg[DS-1])
            BASE_POS1: bterm = ONEV;
            BASE_NEG1: bterm = -ONEV;
            default:   bterm = '0;
        endcase
        val = bterm + rs;
        if (val > MAXV) begin
            value_next = MAXV[W-1:0];
        end else if (val < MINV) begin
            value_next = MINV[W-1:0];
        end else begin
            value_next = val[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[DS]) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### hw/rtl/quaternion_to_basis_vectors_unit.sv
// quaternion_to_basis_vectors_unit: top level, pipeline control and nine divide lanes
// depends on qbv_pkg, qbv_front, qbv_div_lane
//
//  channel | direction | handshake          | word
//  s_      | in        | s_valid / s_ready  | quat_x, quat_y, quat_z, quat_w
//  m_      | out       | m_valid / m_ready  | left/up/fwd a,b,c and zero_norm
//
// the pipe runs through four front stages, then
// COMP_WIDTH + 2 quotient bit stages in each divide lane plus a rounding stage
// one word is taken every cycle while the output keeps moving
// each stage holds when its successor is full and stalled; empty stages still
// fill, so a waiting result does not block input until the pipe is full
// aresetn (synchronous, active low) clears only the stage valid bits
`default_nettype none

module quaternion_to_basis_vectors_unit #(
    parameter int COMP_WIDTH = qbv_pkg::COMP_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [COMP_WIDTH-1:0]   s_quat_x,
    input  wire logic signed [COMP_WIDTH-1:0]   s_quat_y,
    input  wire logic signed [COMP_WIDTH-1:0]   s_quat_z,
    input  wire logic signed [COMP_WIDTH-1:0]   s_quat_w,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [COMP_WIDTH-1:0]        m_left_a,
    output logic signed [COMP_WIDTH-1:0]        m_left_b,
    output logic signed [COMP_WIDTH-1:0]        m_left_c,
    output logic signed [COMP_WIDTH-1:0]        m_up_a,
    output logic signed [COMP_WIDTH-1:0]        m_up_b,
    output logic signed [COMP_WIDTH-1:0]        m_up_c,
    output logic signed [COMP_WIDTH-1:0]        m_fwd_a,
    output logic signed [COMP_WIDTH-1:0]        m_fwd_b,
    output logic signed [COMP_WIDTH-1:0]        m_fwd_c,
    output logic                                m_zero_norm
);
    import qbv_pkg::*;

    localparam int W  = COMP_WIDTH;
    localparam int SW = 2*W + 1;
    localparam int LS = W + 3;              // divide lane stages
    localparam int NS = FRONT_STAGES + LS;  // total stages

    // per-stage valid bits and the ready chain
    logic [NS-1:0]  valid_reg, valid_next;
    logic [NS:0]    rdy;

    always_comb begin
        rdy[NS] = m_ready;
        for (int i = NS-1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        valid_next[0] = rdy[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NS-1];

    // front: halve, products, sums, sign and magnitude
    logic [SW-1:0]  f_s;
    logic           f_zero;
    logic           f_neg [NUM_LANES];
    logic [SW-1:0]  f_mag [NUM_LANES];

    qbv_front #(.W(W)) u_front (
        .aclk     (aclk),
        .ld       (rdy[FRONT_STAGES-1:0]),
        .x        (s_quat_x),
        .y        (s_quat_y),
        .z        (s_quat_z),
        .w        (s_quat_w),
        .s_out    (f_s),
        .zero_out (f_zero),
        .neg_out  (f_neg),
        .mag_out  (f_mag)
    );

    // nine divide lanes, one per matrix entry
    logic signed [W-1:0] lane_out [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        qbv_div_lane #(.W(W)) u_lane (
            .aclk  (aclk),
            .ld    (rdy[NS-1:FRONT_STAGES]),
            .base  (lane_base(k)),
            .neg   (f_neg[k]),
            .mag   (f_mag[k]),
            .s     (f_s),
            .value (lane_out[k])
        );
    end

    // zero-norm flag rides alongside the lanes
    logic zd_reg [LS];

    always_ff @(posedge aclk) begin
        if (rdy[FRONT_STAGES]) begin
            zd_reg[0] <= f_zero;
        end
        for (int j = 1; j < LS; j++) begin
            if (rdy[FRONT_STAGES+j]) begin
                zd_reg[j] <= zd_reg[j-1];
            end
        end
    end

    // zero quaternion forces all vectors to zero
    assign m_zero_norm = zd_reg[LS-1];
    assign m_left_a = m_zero_norm ? '0 : lane_out[0];
    assign m_left_b = m_zero_norm ? '0 : lane_out[1];
    assign m_left_c = m_zero_norm ? '0 : lane_out[2];
    assign m_up_a   = m_zero_norm ? '0 : lane_out[3];
    assign m_up_b   = m_zero_norm ? '0 : lane_out[4];
    assign m_up_c   = m_zero_norm ? '0 : lane_out[5];
    assign m_fwd_a  = m_zero_norm ? '0 : lane_out[6];
    assign m_fwd_b  = m_zero_norm ? '0 : lane_out[7];
    assign m_fwd_c  = m_zero_norm ? '0 : lane_out[8];

`ifndef SYNTH
    // a free stage anywhere or a taken output means input is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!(&valid_reg) || m_ready) |-> s_ready)
        else $error("s_ready low with room in the pipe");

    // full pipe with stalled output must block input
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |-> !s_ready)
        else $error("s_ready high with full stalled pipe");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("m_valid high after reset");

    // nothing comes out of an empty pipe that takes no word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!(|valid_reg) && !(s_valid && s_ready)) |=> !m_valid)
        else $error("result appeared from an empty pipe");
`endif

endmodule

`default_nettype wire
